// ----- src/dba_pkg.sv -----
// Package for the block-average depth downsampler.
// Holds widths, register codes, reset values, shared types and the reciprocal table.
// No dependencies.
package dba_pkg;

  localparam int MaxOutW   = 1024;
  localparam int MaxRatio  = 8;

  localparam int DepthW    = 16;
  localparam int RatioW    = 4;
  localparam int WidthW    = 11;
  localparam int ColW      = $clog2(MaxOutW);
  localparam int SubW      = $clog2(MaxRatio);
  localparam int IcW       = $clog2(MaxOutW * MaxRatio);
  localparam int RowLenW   = IcW + 1;
  localparam int SumW      = 23;
  localparam int CntW      = 7;
  localparam int QW        = 23;
  localparam int DivW      = 17;
  localparam int IterW     = $clog2(QW);
  localparam int MmPerM    = 1000;

  localparam int RecipShift = 17;
  localparam int RecipW     = RecipShift + 1;

  localparam int QDepth    = 4;
  localparam int QPtrW     = $clog2(QDepth);
  localparam int QCntW     = QPtrW + 1;

  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = WidthW;

  localparam logic [CfgIdxW-1:0] CfgIdxRatio = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIdxWidth = 1'b1;

  localparam logic [RatioW-1:0]  RstRatio  = 4'd1;
  localparam logic [WidthW-1:0]  RstWidth  = 11'd640;
  localparam logic [RowLenW-1:0] RstRowLen = 14'd640;

  typedef struct packed {
    logic [SumW-1:0] sum;
    logic [CntW-1:0] cnt;
  } dba_line_t;

  typedef struct packed {
    logic [SumW-1:0] sum;
    logic [CntW-1:0] cnt;
    logic            row_end;
  } dba_job_t;

  typedef struct packed {
    logic     valid;
    dba_job_t job;
  } dba_push_t;

  typedef enum logic [1:0] {
    RS_IDLE,
    RS_EST,
    RS_FIX
  } dba_rs_e;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_MUL,
    DV_RUN,
    DV_WAIT
  } dba_div_e;

  // ceil(2^RecipShift / r) for r in 1..8; exact floor(ic / r) for any 13-bit ic
  function automatic logic [RecipW-1:0] recip_f(input logic [RatioW-1:0] r);
    logic [RecipW-1:0] v;
    case (r)
      4'd1:    v = 18'd131072;
      4'd2:    v = 18'd65536;
      4'd3:    v = 18'd43691;
      4'd4:    v = 18'd32768;
      4'd5:    v = 18'd26215;
      4'd6:    v = 18'd21846;
      4'd7:    v = 18'd18725;
      default: v = 18'd16384;
    endcase
    return v;
  endfunction

endpackage

// ----- src/depth_block_average_to_meters.sv -----
// Block-average depth downsampler, millimetres in, unsigned Q7.16 metres out.
// Throughput: one pixel per cycle while full is low; the divider works on one 23-bit result
//   at a time, one quotient bit per cycle, and a 4-deep job queue absorbs bursts.
// Reset: ratio 1, width 640, position counters cleared; the line store is not cleared.
//   After a register write, full stays high while the column is recomputed.
module depth_block_average_to_meters import dba_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                push,
  output logic                full,
  input  logic [DepthW-1:0]   depth_mm_i,
  input  logic                frame_start_i,
  output logic                empty,
  input  logic                pop,
  output logic [QW-1:0]       depth_m_q16_o,
  output logic                row_end_o
);

  dba_push_t        job_push;
  logic [QCntW-1:0] q_count;
  logic             q_valid;
  dba_job_t         q_job;
  logic             q_pop;

  dba_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_push_i     (push),
    .depth_mm_i    (depth_mm_i),
    .frame_start_i (frame_start_i),
    .q_count_i     (q_count),
    .in_full_o     (full),
    .push_o        (job_push)
  );

  dba_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (q_job),
    .count_o (q_count)
  );

  dba_div u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_job_i       (q_job),
    .q_pop_o       (q_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .depth_m_q16_o (depth_m_q16_o),
    .row_end_o     (row_end_o)
  );

endmodule

// ----- src/dba_front.sv -----
// Front end: configuration registers, raster position tracking and the column line store.
// Accumulates each block's sum and count and queues a job on the last pixel of a block.
// Depends on dba_pkg.
module dba_front import dba_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_push_i,
  input  logic [DepthW-1:0]   depth_mm_i,
  input  logic                frame_start_i,
  input  logic [QCntW-1:0]    q_count_i,
  output logic                in_full_o,
  output dba_push_t           push_o
);

  logic [RatioW-1:0]  ratio_q;
  logic [WidthW-1:0]  width_q;
  logic [RowLenW-1:0] row_len_q;
  logic [IcW-1:0]     ic_q, ic_d;
  logic [ColW-1:0]    col_q, col_d;
  logic [SubW-1:0]    sub_q, sub_d;
  logic [SubW-1:0]    rib_q, rib_d;
  logic [IcW-1:0]     col_est_q;
  dba_rs_e            rs_q, rs_d;

  logic               s1_valid_q;
  logic [ColW-1:0]    s1_col_q;
  logic [DepthW-1:0]  s1_pix_q;
  logic               s1_first_q, s1_last_q, s1_row_end_q;
  dba_line_t          rd_q;
  logic               fwd_valid_q;
  logic [ColW-1:0]    fwd_col_q;
  dba_line_t          fwd_q;

  dba_line_t          line_mem [MaxOutW];

  logic [RatioW-1:0]  eff_r;
  logic [WidthW-1:0]  eff_w;
  logic [WidthW-1:0]  w_m1;
  logic [SubW-1:0]    r_m1;
  logic               busy, est_en, fix_en, accept;
  logic               pos_clr, rib_clr, row_wrap;
  logic [IcW-1:0]     ic_e;
  logic [ColW-1:0]    col_e;
  logic [SubW-1:0]    sub_e, rib_e;
  logic               first_e, last_e, row_end_e;
  logic [RowLenW+RatioW-1:0] row_len_prod;
  logic [IcW+RecipW-1:0]     est_prod;
  logic [IcW+RatioW-1:0]     fix_prod, fix_diff;
  logic [SubW-1:0]    fix_sub;
  logic               s1_emit;
  dba_line_t          line_old, line_new;
  logic               pix_nz;

  // Saturate the raw registers into their working ranges
  always_comb begin
    if (ratio_q == '0) begin
      eff_r = RatioW'(1);
    end else if (ratio_q > RatioW'(MaxRatio)) begin
      eff_r = RatioW'(MaxRatio);
    end else begin
      eff_r = ratio_q;
    end
    if (width_q == '0) begin
      eff_w = WidthW'(1);
    end else if (width_q > WidthW'(MaxOutW)) begin
      eff_w = WidthW'(MaxOutW);
    end else begin
      eff_w = width_q;
    end
  end

  assign w_m1 = eff_w - WidthW'(1);
  assign r_m1 = eff_r[SubW-1:0] - SubW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= RstRatio;
      width_q <= RstWidth;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgIdxRatio: ratio_q <= cfg_data_i[RatioW-1:0];
        CfgIdxWidth: width_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Re-derive column and sub-column from the raw position after a register write
  always_comb begin
    rs_d = rs_q;
    case (rs_q)
      RS_IDLE: if (cfg_we_i) rs_d = RS_EST;
      RS_EST:  rs_d = cfg_we_i ? RS_EST : RS_FIX;
      RS_FIX:  rs_d = cfg_we_i ? RS_EST : RS_IDLE;
      default: rs_d = RS_IDLE;
    endcase
  end

  always_comb begin
    busy   = 1'b1;
    est_en = 1'b0;
    fix_en = 1'b0;
    case (rs_q)
      RS_IDLE: busy = 1'b0;
      RS_EST:  est_en = 1'b1;
      RS_FIX:  fix_en = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q <= RS_IDLE;
    end else begin
      rs_q <= rs_d;
    end
  end

  assign row_len_prod = (RowLenW+RatioW)'(eff_w) * (RowLenW+RatioW)'(eff_r);
  assign est_prod     = (IcW+RecipW)'(ic_q) * (IcW+RecipW)'(recip_f(eff_r));
  assign fix_prod     = (IcW+RatioW)'(col_est_q) * (IcW+RatioW)'(eff_r);
  assign fix_diff     = (IcW+RatioW)'(ic_q) - fix_prod;
  assign fix_sub      = fix_diff[SubW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_len_q <= RstRowLen;
    end else if (est_en) begin
      row_len_q <= row_len_prod[RowLenW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (est_en) begin
      col_est_q <= est_prod[RecipShift +: IcW];
    end
  end

  // Position of the incoming pixel
  assign s1_emit   = s1_valid_q & s1_last_q;
  assign in_full_o = busy | ((q_count_i + QCntW'(s1_emit)) >= QCntW'(QDepth));
  assign accept    = in_push_i & ~in_full_o;

  assign pos_clr  = frame_start_i | ({1'b0, ic_q} >= row_len_q);
  assign rib_clr  = frame_start_i | ({1'b0, rib_q} >= eff_r);
  assign ic_e     = pos_clr ? '0 : ic_q;
  assign col_e    = pos_clr ? '0 : col_q;
  assign sub_e    = pos_clr ? '0 : sub_q;
  assign rib_e    = rib_clr ? '0 : rib_q;
  assign first_e  = (rib_e == '0) & (sub_e == '0);
  assign last_e   = (rib_e == r_m1) & (sub_e == r_m1);
  assign row_end_e = (col_e == w_m1[ColW-1:0]);
  assign row_wrap = ({1'b0, ic_e} == (row_len_q - RowLenW'(1)));

  always_comb begin
    ic_d  = ic_q;
    col_d = col_q;
    sub_d = sub_q;
    rib_d = rib_q;
    if (accept) begin
      if (row_wrap) begin
        ic_d  = '0;
        col_d = '0;
        sub_d = '0;
        rib_d = (rib_e == r_m1) ? '0 : rib_e + SubW'(1);
      end else begin
        ic_d  = ic_e + IcW'(1);
        rib_d = rib_e;
        if (sub_e == r_m1) begin
          sub_d = '0;
          col_d = col_e + ColW'(1);
        end else begin
          sub_d = sub_e + SubW'(1);
          col_d = col_e;
        end
      end
    end else if (fix_en) begin
      col_d = col_est_q[ColW-1:0];
      sub_d = fix_sub;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q  <= '0;
      col_q <= '0;
      sub_q <= '0;
      rib_q <= '0;
    end else begin
      ic_q  <= ic_d;
      col_q <= col_d;
      sub_q <= sub_d;
      rib_q <= rib_d;
    end
  end

  // Read-modify-write of the line store: read on accept, write from the s1 stage in the next cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= line_mem[col_e];
    end
    if (s1_valid_q) begin
      line_mem[s1_col_q] <= line_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= accept;
      fwd_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q     <= col_e;
      s1_pix_q     <= depth_mm_i;
      s1_first_q   <= first_e;
      s1_last_q    <= last_e;
      s1_row_end_q <= row_end_e;
    end
    if (s1_valid_q) begin
      fwd_col_q <= s1_col_q;
      fwd_q     <= line_new;
    end
  end

  // Bypass the write that landed on the same edge as this beat's read
  assign line_old = (fwd_valid_q && (fwd_col_q == s1_col_q)) ? fwd_q : rd_q;
  assign pix_nz   = (s1_pix_q != '0);

  always_comb begin
    line_new = line_old;
    if (s1_first_q) begin
      line_new.sum = pix_nz ? SumW'(s1_pix_q) : '0;
      line_new.cnt = pix_nz ? CntW'(1) : '0;
    end else if (pix_nz) begin
      line_new.sum = line_old.sum + SumW'(s1_pix_q);
      line_new.cnt = line_old.cnt + CntW'(1);
    end
  end

  always_comb begin
    push_o             = '0;
    push_o.valid       = s1_emit;
    push_o.job.sum     = line_new.sum;
    push_o.job.cnt     = line_new.cnt;
    push_o.job.row_end = s1_row_end_q;
  end

endmodule

// ----- src/dba_queue.sv -----
// Short job queue between the accumulating front end and the divider.
// Takes one job per cycle and hands out the oldest; reports its fill level.
// Depends on dba_pkg.
module dba_queue import dba_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dba_push_t        push_i,
  input  logic             pop_i,
  output logic             valid_o,
  output dba_job_t         job_o,
  output logic [QCntW-1:0] count_o
);

  dba_job_t         entry_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d;
  logic [QPtrW-1:0] rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_pop;

  assign valid_o = (cnt_q != '0);
  assign job_o   = entry_q[rd_q];
  assign count_o = cnt_q;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_d  = push_i.valid ? wr_q + QPtrW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + QPtrW'(1) : rd_q;
    cnt_d = cnt_q + QCntW'(push_i.valid) - QCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      entry_q[wr_q] <= push_i.job;
    end
  end

endmodule

// ----- src/dba_div.sv -----
// Back end: turns a block sum and count into metres, unsigned Q7.16, by restoring division.
// One quotient bit per cycle; the result waits in an output register until popped.
// Depends on dba_pkg.
module dba_div import dba_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  dba_job_t        q_job_i,
  output logic            q_pop_o,
  output logic            empty_o,
  input  logic            pop_i,
  output logic [QW-1:0]   depth_m_q16_o,
  output logic            row_end_o
);

  dba_div_e         st_q, st_d;
  dba_job_t         job_q;
  logic [DivW-1:0]  divisor_q;
  logic [DivW-1:0]  rem_q, rem_d;
  logic [QW-1:0]    num_q, num_d;
  logic [IterW-1:0] iter_q;
  logic             zero_q;
  logic             out_valid_q;
  logic [QW-1:0]    out_q;
  logic             out_row_end_q;

  logic             take, start_mul, run_en, load_out, last_iter, out_free;
  logic [DivW:0]    trial, diff;
  logic             qbit;
  logic [DivW+CntW-1:0] div_prod;

  assign last_iter = (iter_q == IterW'(QW - 1));
  assign out_free  = ~out_valid_q | pop_i;

  always_comb begin
    st_d = st_q;
    case (st_q)
      DV_IDLE: if (q_valid_i) st_d = DV_MUL;
      DV_MUL:  st_d = DV_RUN;
      DV_RUN:  if (last_iter) st_d = DV_WAIT;
      DV_WAIT: if (out_free) st_d = DV_IDLE;
      default: st_d = DV_IDLE;
    endcase
  end

  always_comb begin
    take      = 1'b0;
    start_mul = 1'b0;
    run_en    = 1'b0;
    load_out  = 1'b0;
    case (st_q)
      DV_IDLE: take      = q_valid_i;
      DV_MUL:  start_mul = 1'b1;
      DV_RUN:  run_en    = 1'b1;
      DV_WAIT: load_out  = out_free;
      default: take      = 1'b0;
    endcase
  end

  assign q_pop_o = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= DV_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // Remainder stays below the divisor, so one spare bit covers the trial value
  assign div_prod = (DivW+CntW)'(job_q.cnt) * (DivW+CntW)'(MmPerM);
  assign trial    = {rem_q, num_q[QW-1]};
  assign diff     = trial - {1'b0, divisor_q};
  assign qbit     = ~diff[DivW];

  always_comb begin
    rem_d = qbit ? diff[DivW-1:0] : trial[DivW-1:0];
    num_d = {num_q[QW-2:0], qbit};
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      job_q <= q_job_i;
    end
    if (start_mul) begin
      divisor_q <= div_prod[DivW-1:0];
      // sum * 65536: the top bits of the sum form the first partial remainder
      rem_q     <= DivW'(job_q.sum[SumW-1:SumW-DepthW]);
      num_q     <= {job_q.sum[SumW-DepthW-1:0], DepthW'(0)};
      zero_q    <= (job_q.cnt == '0);
      iter_q    <= '0;
    end else if (run_en) begin
      rem_q  <= rem_d;
      num_q  <= num_d;
      iter_q <= iter_q + IterW'(1);
    end
    if (load_out) begin
      out_q         <= zero_q ? '0 : num_q;
      out_row_end_q <= job_q.row_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign empty_o       = ~out_valid_q;
  assign depth_m_q16_o = out_q;
  assign row_end_o     = out_row_end_q;

endmodule

// ----- test/tb_top.sv -----
// Testbench for depth_block_average_to_meters: random and directed depth frames checked
// beat by beat against an in-bench block-mean predictor with its own line store.
// Depends on dba_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_top;
  import dba_pkg::*;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned RandomItems = 100;
  localparam int unsigned MinRandMeans = 12;
  localparam int unsigned IdleCycles  = 40;

  typedef struct packed {
    logic [QW-1:0] mean;
    logic          row_end;
  } mean_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = CfgIdxRatio;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                push = 1'b0;
  logic                full;
  logic [DepthW-1:0]   depth_mm = '0;
  logic                frame_start = 1'b0;
  logic                empty;
  logic                pop = 1'b0;
  logic [QW-1:0]       depth_m_q16;
  logic                row_end;

  // predictor state
  logic [SumW-1:0]   line_sum [MaxOutW];
  logic [CntW-1:0]   line_cnt [MaxOutW];
  int unsigned       in_col = 0;
  int unsigned       blk_row = 0;
  logic [RatioW-1:0] blk_ratio = RstRatio;
  logic [WidthW-1:0] out_width = RstWidth;

  mean_t       mean_q[$];
  int unsigned n_sent = 0;
  int unsigned n_predicted = 0;
  int unsigned n_errors = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned pop_run = 0;

  depth_block_average_to_meters u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .push          (push),
    .full          (full),
    .depth_mm_i    (depth_mm),
    .frame_start_i (frame_start),
    .empty         (empty),
    .pop           (pop),
    .depth_m_q16_o (depth_m_q16),
    .row_end_o     (row_end)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: hold pop at one level for a random run, then pick again
  always @(posedge clk_i) begin
    if (pop_run != 0) begin
      pop_run <= pop_run - 1;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      pop     <= 1'b0;
      pop_run <= $urandom_range(30, 1);
    end else begin
      pop     <= 1'b1;
      pop_run <= $urandom_range(20, 0);
    end
  end

  task automatic flag_error(input string what, input int unsigned want, input int unsigned got);
    n_errors++;
    if (n_errors <= 10) begin
      $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_beats
    mean_t want;
    if (rst_ni && pop && !empty) begin
      if (mean_q.size() == 0) begin
        flag_error("beat with nothing pending, depth_m_q16", 0, depth_m_q16);
      end else begin
        want = mean_q.pop_front();
        if (depth_m_q16 !== want.mean) flag_error("depth_m_q16", want.mean, depth_m_q16);
        if (row_end !== want.row_end) flag_error("row_end", want.row_end, row_end);
      end
    end
  end

  // Advance the line store by one pixel; return 1 when a block completes.
  function automatic bit predict_block_mean(input logic [DepthW-1:0] pix, input logic start,
                                            output mean_t res);
    int unsigned r, w, row_len, col, sub;
    logic [63:0] scaled, divisor;
    bit done;
    r = (blk_ratio == '0) ? 1 : (blk_ratio > MaxRatio) ? MaxRatio : blk_ratio;
    w = (out_width == '0) ? 1 : (out_width > MaxOutW) ? MaxOutW : out_width;
    row_len = w * r;
    res = '0;
    done = 1'b0;
    if (start) begin
      in_col = 0;
      blk_row = 0;
    end
    if (in_col >= row_len) in_col = 0;
    if (blk_row >= r) blk_row = 0;
    col = in_col / r;
    sub = in_col % r;
    // first pixel of a block in the top row of a block row restarts the column
    if (blk_row == 0 && sub == 0) begin
      line_sum[col] = pix;
      line_cnt[col] = (pix != '0);
    end else if (pix != '0) begin
      line_sum[col] = line_sum[col] + pix;
      line_cnt[col] = line_cnt[col] + 1'b1;
    end
    if (blk_row == r - 1 && sub == r - 1) begin
      if (line_cnt[col] != '0) begin
        scaled  = {41'd0, line_sum[col]} << 16;
        divisor = {57'd0, line_cnt[col]} * MmPerM;
        res.mean = scaled / divisor;
      end
      res.row_end = (col == w - 1);
      done = 1'b1;
    end
    in_col++;
    if (in_col >= row_len) begin
      in_col = 0;
      blk_row++;
      if (blk_row >= r) blk_row = 0;
    end
    return done;
  endfunction

  task automatic send_pixel(input logic [DepthW-1:0] pix, input logic start);
    mean_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
        push <= 1'b0;
        repeat ($urandom_range(12, 1)) @(posedge clk_i);
      end
    end
    burst_left--;
    push        <= 1'b1;
    depth_mm    <= pix;
    frame_start <= start;
    do @(posedge clk_i); while (full);
    n_sent++;
    if (predict_block_mean(pix, start, res)) begin
      mean_q.push_back(res);
      n_predicted++;
    end
  endtask

  // drop push, drain all pending means, then let the pipeline go quiet
  task automatic settle();
    push <= 1'b0;
    while (mean_q.size() != 0) @(posedge clk_i);
    repeat (IdleCycles) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [RatioW-1:0] ratio, input logic [WidthW-1:0] width);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgIdxRatio;
    cfg_data <= CfgDataW'(ratio);
    @(posedge clk_i);
    cfg_idx  <= CfgIdxWidth;
    cfg_data <= width;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    blk_ratio = ratio;
    out_width = width;
  endtask

  function automatic logic [DepthW-1:0] rand_depth(input int unsigned zero_pct);
    int unsigned k;
    k = $urandom_range(99);
    if (k < zero_pct) return '0;
    if (k < zero_pct + 8) return '1;
    if (k < zero_pct + 12) return DepthW'($urandom_range(15, 1));
    return DepthW'($urandom_range(65535, 1));
  endfunction

  task automatic test_reset_defaults();
    logic [DepthW-1:0] pix [10];
    int unsigned i;
    pix = '{16'd0, 16'd1, 16'd65535, 16'd1000, 16'd999, 16'd1001, 16'd32768, 16'd0,
            16'd12345, 16'd500};
    gap_pct = 30;
    stall_pct = 30;
    for (i = 0; i < 10; i++) send_pixel(pix[i], i == 0 || i == 5);
    settle();
  endtask

  task automatic test_ratio_width_limits();
    int unsigned i;
    gap_pct = 0;
    stall_pct = 0;
    // zero ratio and zero width both act as one: every pixel ends a row
    set_config('0, '0);
    for (i = 0; i < 4; i++) send_pixel(i[0] ? 16'hFFFF : 16'd7, i == 0);
    settle();
    // ratio above the maximum saturates: full block of max depth, empty block, lone pixel
    set_config(4'd15, 11'd1);
    for (i = 0; i < 64; i++) send_pixel(16'hFFFF, i == 0);
    for (i = 0; i < 64; i++) send_pixel('0, 1'b0);
    for (i = 0; i < 64; i++) send_pixel((i == 37) ? 16'd1 : 16'd0, 1'b0);
    settle();
  endtask

  task automatic test_widest_row();
    int unsigned i;
    gap_pct = 25;
    stall_pct = 30;
    set_config(4'd1, 11'd2047);
    for (i = 0; i < 60; i++) send_pixel(rand_depth(20), i == 0);
    settle();
  endtask

  task automatic test_block_row_overwrite();
    int unsigned i;
    gap_pct = 60;
    stall_pct = 70;
    set_config(4'd2, 11'd2);
    for (i = 0; i < 24; i++) send_pixel(DepthW'((i + 1) * 1111), i == 0);
    settle();
  endtask

  task automatic test_frame_restart();
    int unsigned i;
    gap_pct = 0;
    stall_pct = 30;
    set_config(4'd2, 11'd3);
    for (i = 0; i < 9; i++) send_pixel(16'd4000, i == 0);
    // restart mid block row; the partial blocks are dropped
    for (i = 0; i < 12; i++) send_pixel(rand_depth(25), i == 0);
    settle();
  endtask

  task automatic test_position_wrap();
    int unsigned i;
    gap_pct = 25;
    stall_pct = 0;
    set_config(4'd1, 11'd8);
    for (i = 0; i < 6; i++) send_pixel(rand_depth(10), i == 0);
    settle();
    // column now beyond the shorter row: restarts at zero
    set_config(4'd1, 11'd4);
    for (i = 0; i < 5; i++) send_pixel(rand_depth(10), 1'b0);
    settle();
    set_config(4'd4, 11'd1);
    for (i = 0; i < 8; i++) send_pixel(rand_depth(10), i == 0);
    settle();
    // row within block now beyond the smaller ratio: restarts at zero
    set_config(4'd2, 11'd1);
    for (i = 0; i < 4; i++) send_pixel(rand_depth(10), 1'b0);
    settle();
  endtask

  task automatic test_random_frames();
    int unsigned first_item, first_res, er, ew, n_px, k, zero_pct, i;
    logic [RatioW-1:0] ratio;
    logic [WidthW-1:0] width;
    first_item = n_sent;
    first_res = n_predicted;
    while (n_sent - first_item < RandomItems || n_predicted - first_res < MinRandMeans) begin
      k = $urandom_range(99);
      if (k < 70) ratio = RatioW'($urandom_range(4, 1));
      else if (k < 90) ratio = RatioW'($urandom_range(8, 5));
      else if (k < 95) ratio = '0;
      else ratio = RatioW'($urandom_range(15, 9));
      er = (ratio == '0) ? 1 : (ratio > MaxRatio) ? MaxRatio : ratio;
      if (er <= 3 && $urandom_range(9) == 0) width = WidthW'($urandom_range(16, 7));
      else if ($urandom_range(19) == 0) width = '0;
      else width = WidthW'($urandom_range((er >= 5) ? 3 : 6, 1));
      ew = (width == '0) ? 1 : width;
      n_px = ew * er * er * $urandom_range(3, 1);
      // some frames stop short in the middle of a block
      if ($urandom_range(4) == 0) n_px = $urandom_range(n_px, 1);
      zero_pct = ($urandom_range(3) == 0) ? 85 : $urandom_range(30);
      k = $urandom_range(2);
      gap_pct = (k == 0) ? 0 : (k == 1) ? 25 : 60;
      k = $urandom_range(2);
      stall_pct = (k == 0) ? 0 : (k == 1) ? 30 : 70;
      set_config(ratio, width);
      for (i = 0; i < n_px; i++) begin
        send_pixel(rand_depth(zero_pct), i == 0 || $urandom_range(99) < 2);
      end
      settle();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);
    test_reset_defaults();
    test_ratio_width_limits();
    test_block_row_overwrite();
    test_frame_restart();
    test_position_wrap();
    test_widest_row();
    test_random_frames();
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- depth_block_average_to_meters.f -----
src/dba_pkg.sv
src/dba_front.sv
src/dba_queue.sv
src/dba_div.sv
src/depth_block_average_to_meters.sv
test/tb_top.sv
